### rtl/core/hhsp_pkg.sv
package hhsp_pkg;

  localparam int WIN = 14;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_HEADER = 3'd1,
    PH_BODY   = 3'd2,
    PH_DONE   = 3'd3,
    PH_FAILED = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    VS_SKIP = 2'd0,
    VS_POS  = 2'd1,
    VS_NEG  = 2'd2,
    VS_STOP = 2'd3
  } vscan_t;

  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;

  localparam logic [2:0] M_UNKNOWN = 3'd0;
  localparam logic [2:0] M_GET     = 3'd1;
  localparam logic [2:0] M_RESP    = 3'd2;
  localparam logic [2:0] M_POST    = 3'd3;
  localparam logic [2:0] M_PUT     = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } beat_t;

  typedef logic [WIN-1:0][7:0] window_t;

  // true when the last len-1 window bytes plus b spell s (s right aligned, ascii)
  function automatic logic ends_with(input window_t w, input logic [7:0] b,
                                     input logic [8*14-1:0] s, input int len);
    logic ok;
    ok = (s[7:0] == b);
    for (int k = 1; k < 14; k++) begin
      if (k < len && s[8*k +: 8] != w[WIN-k]) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

### rtl/core/hhsp_front.sv
module hhsp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_data_byte,
  input  logic           in_end_of_data,
  output logic           q_valid,
  input  logic           q_pop,
  output hhsp_pkg::beat_t q_beat
);
  import hhsp_pkg::*;

  // two-entry queue between input port and parser
  beat_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_beat   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{data_byte: in_data_byte, end_of_data: in_end_of_data};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

### rtl/core/hhsp_back.sv
module hhsp_back #(
  parameter int LINE_BYTES  = 128,
  parameter int NAME_BYTES  = 16,
  parameter int VALUE_BYTES = 32,
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  hhsp_pkg::beat_t        q_beat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [2:0]             out_method,
  output logic                   out_header_done,
  output logic                   out_is_body_byte,
  output logic [23:0]            out_body_index,
  output logic [23:0]            out_decoded_length,
  output logic                   out_length_seen,
  output logic                   out_connection_seen,
  output logic                   out_host_seen,
  output logic                   out_content_type_seen
);
  import hhsp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] MAXLEN = '1;
  localparam int AW = LENGTH_BITS + 4;

  phase_t                 phase_r, phase_nxt;
  window_t                win_r, win_nxt;
  logic [7:0]             lpos_r, lpos_nxt;
  logic [2:0]             meth_r, meth_nxt;
  logic [3:0]             seen_r, seen_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] bcnt_r, bcnt_nxt;
  vscan_t                 vs_r, vs_nxt;
  logic                   pcr_r, pcr_nxt;
  logic [2:0]             rank_r, rank_nxt;
  logic                   colon_r, colon_nxt;
  logic                   nlong_r, nlong_nxt;
  logic [3:0]             hits_r, hits_nxt;
  logic [6:0]             vcnt_r, vcnt_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;

  logic                   body;
  logic [LENGTH_BITS-1:0] idx;
  logic                   fire;

  // output register, loaded whenever empty or being taken
  assign fire  = q_valid && (!out_valid || !out_stall);
  assign q_pop = fire;

  // one byte into the current line
  function automatic void do_feed(input logic [7:0] b,
      inout phase_t ph, inout window_t w, inout logic [7:0] lp, inout logic [2:0] rk,
      inout logic cl, inout logic nl, inout logic [3:0] hs, inout logic [6:0] vc,
      inout vscan_t vs, inout logic [LENGTH_BITS-1:0] ac);
    logic sp, dg, acc_go;
    logic [AW-1:0] t;
    if (32'(lp) >= LINE_BYTES) begin
      ph = PH_FAILED;
    end else begin
      lp = lp + 8'd1;
      if (ph == PH_FIRST) begin
        if (rk > 3'd0 && ends_with(w, b, {88'h0, "GET"}, 3)) rk = 3'd0;
        else if (rk > 3'd1 && ends_with(w, b, {80'h0, "POST"}, 4)) rk = 3'd1;
        else if (rk > 3'd2 && ends_with(w, b, {88'h0, "PUT"}, 3)) rk = 3'd2;
        else if (rk > 3'd3 && ends_with(w, b, {48'h0, "HTTP/1.1"}, 8)) rk = 3'd3;
      end else if (!cl) begin
        if (b == CH_COLON) cl = 1'b1;
        else if (32'(lp) > NAME_BYTES - 1) nl = 1'b1;
        else begin
          if (ends_with(w, b, "Content-Length", 14)) hs[0] = 1'b1;
          if (ends_with(w, b, {32'h0, "Connection"}, 10)) hs[1] = 1'b1;
          if (ends_with(w, b, {80'h0, "Host"}, 4)) hs[2] = 1'b1;
          if (ends_with(w, b, {16'h0, "Content-Type"}, 12)) hs[3] = 1'b1;
        end
      end else if (32'(vc) < VALUE_BYTES - 1) begin
        vc = vc + 7'd1;
        sp = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
        dg = (b >= 8'h30 && b <= 8'h39);
        acc_go = 1'b0;
        unique case (vs)
          VS_SKIP: begin
            if (sp) ;
            else if (b == 8'h2b) vs = VS_POS;
            else if (b == 8'h2d) vs = VS_NEG;
            else if (!dg) vs = VS_STOP;
            else begin vs = VS_POS; acc_go = 1'b1; end
          end
          VS_STOP: ;
          default: begin
            if (!dg) vs = VS_STOP;
            else acc_go = 1'b1;
          end
        endcase
        if (acc_go) begin
          // x*10 = x*8 + x*2
          t = {ac, 3'b0} + {3'b0, ac, 1'b0} + AW'(b[3:0]);
          ac = (t > AW'(MAXLEN)) ? MAXLEN : t[LENGTH_BITS-1:0];
        end
      end
      w = {b, w[WIN-1:1]};
    end
  endfunction

  always_comb begin
    phase_nxt = phase_r; win_nxt = win_r; lpos_nxt = lpos_r; meth_nxt = meth_r;
    seen_nxt = seen_r; len_nxt = len_r; bcnt_nxt = bcnt_r; vs_nxt = vs_r;
    pcr_nxt = pcr_r; rank_nxt = rank_r; colon_nxt = colon_r; nlong_nxt = nlong_r;
    hits_nxt = hits_r; vcnt_nxt = vcnt_r; acc_nxt = acc_r;
    body = 1'b0;
    idx = '0;
    if (phase_r == PH_DONE) begin
      phase_nxt = PH_FIRST; win_nxt = '0; lpos_nxt = '0; meth_nxt = M_UNKNOWN;
      seen_nxt = '0; len_nxt = '0; bcnt_nxt = '0; vs_nxt = VS_SKIP; pcr_nxt = 1'b0;
      rank_nxt = 3'd4; colon_nxt = 1'b0; nlong_nxt = 1'b0; hits_nxt = '0;
      vcnt_nxt = '0; acc_nxt = '0;
    end
    if (phase_nxt != PH_FAILED) begin
      if (q_beat.end_of_data) begin
        if (phase_nxt == PH_BODY) phase_nxt = PH_DONE;
      end else if (phase_nxt == PH_BODY) begin
        body = 1'b1;
        idx = bcnt_nxt;
        bcnt_nxt = bcnt_nxt + 1'b1;
        if (bcnt_nxt >= len_nxt) phase_nxt = PH_DONE;
      end else if (pcr_nxt && q_beat.data_byte == CH_LF) begin
        pcr_nxt = 1'b0;
        // end of line
        if (lpos_nxt == 8'd0) begin
          phase_nxt = (!seen_nxt[0] || len_nxt == '0) ? PH_DONE : PH_BODY;
        end else if (phase_nxt == PH_FIRST) begin
          unique case (rank_nxt)
            3'd0:    meth_nxt = M_GET;
            3'd1:    meth_nxt = M_POST;
            3'd2:    meth_nxt = M_PUT;
            3'd3:    meth_nxt = M_RESP;
            default: meth_nxt = M_UNKNOWN;
          endcase
          phase_nxt = PH_HEADER;
        end else if (colon_nxt && !nlong_nxt) begin
          priority if (hits_nxt[0]) begin
            len_nxt = (vs_nxt == VS_NEG) ? '0 : acc_nxt;
            seen_nxt[0] = 1'b1;
          end else if (hits_nxt[1]) seen_nxt[1] = 1'b1;
          else if (hits_nxt[2]) seen_nxt[2] = 1'b1;
          else if (hits_nxt[3]) seen_nxt[3] = 1'b1;
        end
        win_nxt = '0; lpos_nxt = '0; colon_nxt = 1'b0; nlong_nxt = 1'b0;
        hits_nxt = '0; vcnt_nxt = '0; vs_nxt = VS_SKIP; acc_nxt = '0;
      end else begin
        if (pcr_nxt)
          do_feed(CH_CR, phase_nxt, win_nxt, lpos_nxt, rank_nxt, colon_nxt, nlong_nxt,
                  hits_nxt, vcnt_nxt, vs_nxt, acc_nxt);
        if (phase_nxt != PH_FAILED) begin
          if (q_beat.data_byte == CH_CR) pcr_nxt = 1'b1;
          else begin
            pcr_nxt = 1'b0;
            do_feed(q_beat.data_byte, phase_nxt, win_nxt, lpos_nxt, rank_nxt, colon_nxt,
                    nlong_nxt, hits_nxt, vcnt_nxt, vs_nxt, acc_nxt);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST; win_r <= '0; lpos_r <= '0; meth_r <= M_UNKNOWN;
      seen_r <= '0; len_r <= '0; bcnt_r <= '0; vs_r <= VS_SKIP; pcr_r <= 1'b0;
      rank_r <= 3'd4; colon_r <= 1'b0; nlong_r <= 1'b0; hits_r <= '0;
      vcnt_r <= '0; acc_r <= '0; out_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt; win_r <= win_nxt; lpos_r <= lpos_nxt; meth_r <= meth_nxt;
        seen_r <= seen_nxt; len_r <= len_nxt; bcnt_r <= bcnt_nxt; vs_r <= vs_nxt;
        pcr_r <= pcr_nxt; rank_r <= rank_nxt; colon_r <= colon_nxt;
        nlong_r <= nlong_nxt; hits_r <= hits_nxt; vcnt_r <= vcnt_nxt; acc_r <= acc_nxt;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= (phase_nxt == PH_DONE) ? ST_DONE :
                    (phase_nxt == PH_FAILED) ? ST_FAILED : ST_PARSING;
      out_method <= (phase_nxt == PH_FIRST) ? M_UNKNOWN : meth_nxt;
      out_header_done <= (phase_nxt == PH_BODY) || (phase_nxt == PH_DONE);
      out_is_body_byte <= body;
      out_body_index <= 24'(idx);
      out_decoded_length <= 24'(len_nxt);
      out_length_seen <= seen_nxt[0];
      out_connection_seen <= seen_nxt[1];
      out_host_seen <= seen_nxt[2];
      out_content_type_seen <= seen_nxt[3];
    end
  end
endmodule

### rtl/core/http_header_stream_parser.sv
// http header stream parser: takes one message byte per beat and returns one
// result beat per input beat, at a sustained rate of one beat per cycle when
// out_stall is low (a two-entry input queue, then a combinational parse
// step into the output register). the parse step holds the whole per-byte
// update, including the content-length multiply-by-ten, so it sets the clock.
module http_header_stream_parser #(
  parameter int LINE_BYTES  = 128,
  parameter int NAME_BYTES  = 16,
  parameter int VALUE_BYTES = 32,
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_method,
  output logic        out_header_done,
  output logic        out_is_body_byte,
  output logic [23:0] out_body_index,
  output logic [23:0] out_decoded_length,
  output logic        out_length_seen,
  output logic        out_connection_seen,
  output logic        out_host_seen,
  output logic        out_content_type_seen
);
  import hhsp_pkg::*;

  // queue handoff between front and back
  logic  q_valid, q_pop;
  beat_t q_beat;

  hhsp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_end_of_data,
    .q_valid, .q_pop, .q_beat
  );

  hhsp_back #(
    .LINE_BYTES(LINE_BYTES), .NAME_BYTES(NAME_BYTES),
    .VALUE_BYTES(VALUE_BYTES), .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_beat, .out_valid, .out_stall,
    .out_status, .out_method, .out_header_done, .out_is_body_byte,
    .out_body_index, .out_decoded_length, .out_length_seen,
    .out_connection_seen, .out_host_seen, .out_content_type_seen
  );
endmodule

### rtl/core/hhsp_checker.sv
module hhsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_header_done,
  input logic        out_is_body_byte,
  input logic [23:0] out_body_index
);
  import hhsp_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  a_body_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_body_byte |-> out_header_done)
    else $error("body beat before header end");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_body_byte |-> out_body_index == 24'd0)
    else $error("index without body beat");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");
endmodule

bind http_header_stream_parser hhsp_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_status, .out_header_done,
  .out_is_body_byte, .out_body_index
);

### sim/tb_http_header_stream_parser.sv
module tb_http_header_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import hhsp_pkg::*;

  localparam int LINE_MAX  = 128;
  localparam int NAME_MAX  = 16;
  localparam int VALUE_MAX = 32;
  localparam logic [23:0] LEN_SAT = 24'hFFFFFF;

  // scanner states for the length value
  localparam int SC_SKIP = 0;
  localparam int SC_POS  = 1;
  localparam int SC_NEG  = 2;
  localparam int SC_STOP = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_data = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_method;
  logic        out_header_done;
  logic        out_is_body_byte;
  logic [23:0] out_body_index;
  logic [23:0] out_decoded_length;
  logic        out_length_seen;
  logic        out_connection_seen;
  logic        out_host_seen;
  logic        out_content_type_seen;

  http_header_stream_parser dut (.*);

  always #6 clk = ~clk;

  // one expected result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  method;
    logic        header_done;
    logic        is_body;
    logic [23:0] body_index;
    logic [23:0] decoded_length;
    logic [3:0]  seen;
  } parse_result_t;

  parse_result_t pending_results[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int messages_done = 0;
  int body_beats = 0;
  bit idle_on = 1'b1;
  bit hold_rx = 1'b0;
  int hold_cycles = 0;
  int rx_idle_left = 0;

  // ---------------------------------------------------------------------
  // parser shadow state
  // ---------------------------------------------------------------------
  phase_t      ph;
  logic [7:0]  win[WIN];
  int          lpos;
  logic [2:0]  meth;
  logic [3:0]  seen;
  logic [23:0] len_val;
  logic [23:0] body_cnt;
  int          scan;
  bit          prev_cr;
  int          rank;
  bit          colon;
  bit          name_long;
  logic [3:0]  name_hits;
  int          vcount;
  longint      accum;

  string pats[8] = '{"GET", "POST", "PUT", "HTTP/1.1",
                     "Content-Length", "Connection", "Host", "Content-Type"};
  logic [2:0] first_code[4] = '{M_GET, M_POST, M_PUT, M_RESP};

  function automatic void clear_line();
    foreach (win[k]) win[k] = 8'd0;
    lpos = 0; colon = 0; name_long = 0; name_hits = 4'd0;
    vcount = 0; scan = SC_SKIP; accum = 0;
  endfunction

  function automatic void clear_message();
    clear_line();
    ph = PH_FIRST; meth = M_UNKNOWN; rank = 4; seen = 4'd0;
    len_val = 24'd0; body_cnt = 24'd0; prev_cr = 0;
  endfunction

  // window tail plus the new byte spells pattern p
  function automatic bit tail_matches(int p, logic [7:0] b);
    int n;
    n = pats[p].len();
    if (pats[p][n-1] != b) return 0;
    for (int k = 0; k < n - 1; k++)
      if (pats[p][k] != win[WIN - (n - 1) + k]) return 0;
    return 1;
  endfunction

  function automatic void scan_length(logic [7:0] b);
    bit sp, dg;
    sp = (b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0b || b == 8'h0c || b == 8'h0d);
    dg = (b >= "0" && b <= "9");
    if (scan == SC_SKIP) begin
      if (sp) return;
      if (b == "+") begin scan = SC_POS; return; end
      if (b == "-") begin scan = SC_NEG; return; end
      if (!dg) begin scan = SC_STOP; return; end
      scan = SC_POS;
    end else if (scan == SC_STOP) begin
      return;
    end else if (!dg) begin
      scan = SC_STOP;
      return;
    end
    accum = accum * 10 + (b - "0");
    if (accum > LEN_SAT) accum = LEN_SAT;
  endfunction

  function automatic void take_line_byte(logic [7:0] b);
    if (lpos >= LINE_MAX) begin
      ph = PH_FAILED;
      return;
    end
    lpos++;
    if (ph == PH_FIRST) begin
      for (int p = 0; p < 4; p++)
        if (p < rank && tail_matches(p, b)) rank = p;
    end else if (!colon) begin
      if (b == CH_COLON) colon = 1;
      else if (lpos > NAME_MAX - 1) name_long = 1;
      else
        for (int p = 0; p < 4; p++)
          if (tail_matches(4 + p, b)) name_hits[p] = 1'b1;
    end else if (vcount < VALUE_MAX - 1) begin
      vcount++;
      scan_length(b);
    end
    for (int k = 0; k < WIN - 1; k++) win[k] = win[k+1];
    win[WIN-1] = b;
  endfunction

  function automatic void close_line();
    if (lpos == 0) begin
      ph = (!seen[0] || len_val == 0) ? PH_DONE : PH_BODY;
    end else if (ph == PH_FIRST) begin
      meth = (rank < 4) ? first_code[rank] : M_UNKNOWN;
      ph = PH_HEADER;
    end else if (colon && !name_long) begin
      for (int p = 0; p < 4; p++)
        if (name_hits[p]) begin
          if (p == 0) len_val = (scan == SC_NEG) ? 24'd0 : accum[23:0];
          seen[p] = 1'b1;
          break;
        end
    end
    clear_line();
  endfunction

  function automatic parse_result_t parse_step(logic [7:0] b, bit eod);
    parse_result_t r;
    bit body;
    logic [23:0] idx;
    body = 0; idx = 24'd0;
    if (ph == PH_DONE) clear_message();
    if (ph != PH_FAILED) begin
      if (eod) begin
        if (ph == PH_BODY) ph = PH_DONE;
      end else if (ph == PH_BODY) begin
        body = 1; idx = body_cnt; body_cnt++;
        if (body_cnt >= len_val) ph = PH_DONE;
      end else if (prev_cr) begin
        if (b == CH_LF) begin
          prev_cr = 0;
          close_line();
        end else begin
          // lone cr is an ordinary line byte
          take_line_byte(CH_CR);
          if (ph != PH_FAILED) begin
            if (b == CH_CR) prev_cr = 1;
            else begin
              prev_cr = 0;
              take_line_byte(b);
            end
          end
        end
      end else if (b == CH_CR) begin
        prev_cr = 1;
      end else begin
        take_line_byte(b);
      end
    end
    r.status = (ph == PH_DONE) ? ST_DONE : (ph == PH_FAILED) ? ST_FAILED : ST_PARSING;
    r.method = (ph == PH_FIRST) ? M_UNKNOWN : meth;
    r.header_done = (ph == PH_BODY || ph == PH_DONE);
    r.is_body = body;
    r.body_index = idx;
    r.decoded_length = len_val;
    r.seen = seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // sender: one beat, with random idle bursts before it; valid stays high
  // after the beat so the next one can follow without a gap
  // ---------------------------------------------------------------------
  task automatic send_beat(logic [7:0] b, bit eod);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_data <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(parse_step(b, eod));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_beat(s[k], 1'b0);
  endtask

  task automatic send_body(int n);
    repeat (n) send_beat(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stall bursts, plus a long hold when asked
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_rx) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else if (idle_on && rx_idle_left > 0) begin
      out_stall <= 1'b1;  // rest of the burst
      rx_idle_left <= rx_idle_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      rx_idle_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    parse_result_t e, a;
    if (rst_n && out_valid && !out_stall) begin
      a = '{out_status, out_method, out_header_done, out_is_body_byte, out_body_index,
            out_decoded_length, {out_content_type_seen, out_host_seen,
                                 out_connection_seen, out_length_seen}};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $realtime, a);
      end else begin
        e = pending_results.pop_front();
        beats_checked++;
        if (a.is_body) body_beats++;
        if (a.status == ST_DONE) messages_done++;
        if (a !== e) begin
          errors++;
          $display("%0t: mismatch exp st=%0d m=%0d hd=%0b bb=%0b bi=%0d cl=%0d seen=%b",
                   $realtime, e.status, e.method, e.header_done, e.is_body,
                   e.body_index, e.decoded_length, e.seen);
          $display("%0t:          act st=%0d m=%0d hd=%0b bb=%0b bi=%0d cl=%0d seen=%b",
                   $realtime, a.status, a.method, a.header_done, a.is_body,
                   a.body_index, a.decoded_length, a.seen);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_directed_requests();
    // get with host, then zero length finishes at the blank line
    send_text("GET / HTTP/1.1\r\nHost: a\r\nContent-Length: 0\r\n\r\n");
    // post with body, signed and padded value
    send_text("POST /x\r\nContent-Length:  +3\r\nConnection: k\r\n\r\n");
    send_body(3);
    // response, negative length gives zero
    send_text("HTTP/1.1 200\r\nContent-Type: t\r\nContent-Length: -5\r\n\r\n");
    // put, saturating length then body cut by end of data
    send_text("PUT\r\nContent-Length: 99999999999\r\nContent-Length: 2\r\n\r\n");
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    // blank first line, unknown method
    send_text("\r\n");
    // lone cr, no colon, name too long, nul bytes, end of data mid header
    send_text("X\rY");
    send_beat(8'h00, 1'b0);
    send_text("\r\nnocolon\r\nAVeryLongHeaderName-Content-Length: 7\r\n");
    send_beat(8'h00, 1'b1);
    send_text("\r\n");
  endtask

  function automatic string rand_token(int n);
    string s;
    s = "";
    for (int k = 0; k < n; k++) s = {s, string'(byte'($urandom_range(33, 126)))};
    return s;
  endfunction

  task automatic random_message();
    string names[6] = '{"Content-Length", "Connection", "Host", "Content-Type",
                        "X-Other", "content-length"};
    string firsts[5] = '{"GET /", "POST /", "PUT /", "HTTP/1.1 200", "FOO /"};
    int blen, lines;
    blen = 0;
    send_text({firsts[$urandom_range(0, 4)], rand_token($urandom_range(0, 6)), "\r\n"});
    lines = $urandom_range(0, 3);
    for (int i = 0; i < lines; i++) begin
      int pick;
      pick = $urandom_range(0, 5);
      if (pick == 0) begin
        blen = $urandom_range(0, 6);
        send_text($sformatf("Content-Length: %0d\r\n", blen));
      end else if ($urandom_range(0, 9) == 0) begin
        send_text({rand_token($urandom_range(1, 8)), "\r\n"});  // noise line
      end else begin
        send_text({names[pick], ":", rand_token($urandom_range(0, 4)), "\r\n"});
      end
    end
    send_text("\r\n");
    if (blen > 0) begin
      if ($urandom_range(0, 5) == 0) begin
        send_body($urandom_range(0, blen - 1));
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_body(blen);
      end
    end
  endtask

  task automatic test_random_messages(int beat_budget);
    int stop_at;
    stop_at = beats_sent + beat_budget;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0)
        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);  // raw noise
      else
        random_message();
    end
  endtask

  // receiver holds for a long stretch while the sender keeps offering beats
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      send_text("GET /full HTTP/1.1\r\nHost: h\r\n\r\n");
      begin
        wait (hold_cycles >= 60);
        hold_rx = 1'b0;
      end
    join
  endtask

  // overflowing line latches failure until reset; run last
  task automatic test_line_overflow();
    string s;
    s = "GET ";
    repeat (125) s = {s, "a"};
    send_text(s);
    send_text("\r\nHost: x\r\n\r\n");
  endtask

  initial begin
    clear_message();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_requests();
    test_backpressure();
    test_random_messages(20);
    idle_on = 1'b0;  // closing stretch at full rate
    test_random_messages(20);
    test_line_overflow();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
    $display("covered %0d beats checked, %0d messages complete, %0d body beats",
             beats_checked, messages_done, body_beats);
    $display("directed methods, length edge cases, long backpressure hold and line overflow");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
